// ===== rtl/core/hrk_pkg.sv =====
`timescale 1ns / 1ps

package hrk_pkg;

    localparam int MATRIX_ROWS  = 11;
    localparam int MATRIX_COLS  = 8;
    localparam int REPORT_SLOTS = 6;

    localparam int MAX_SLOTS = 6;
    localparam int ROW_W     = (MATRIX_ROWS > 1) ? $clog2(MATRIX_ROWS) : 1;
    localparam int COL_W     = (MATRIX_COLS > 1) ? $clog2(MATRIX_COLS) : 1;
    localparam int SLOT_W    = (REPORT_SLOTS > 1) ? $clog2(REPORT_SLOTS) : 1;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(REPORT_SLOTS - 1);

    localparam logic [7:0] MOD_CODE_BASE = 8'hE0;

    localparam logic REQ_REPORT = 1'b0;
    localparam logic REQ_SCAN   = 1'b1;

    typedef logic [7:0]             t_code;
    typedef logic [MATRIX_COLS-1:0] t_row;

    typedef struct packed {
        logic                      req_type;
        logic [7:0]                modifier_bits;
        t_code [MAX_SLOTS-1:0]     keycodes;
        logic [3:0]                row_pins;
        logic                      dir_read;
    } t_req;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN,
        OP_MOD,
        OP_CLEAR,
        OP_PRESS,
        OP_RELEASE,
        OP_COMMIT
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [SLOT_W-1:0] slot;
    } t_cmd;

    typedef struct packed {
        logic keys_empty;
        logic out_free;
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_CLEAR,
        ST_PRESS,
        ST_RELEASE,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic       hit;
        logic [3:0] row;
        logic [2:0] col;
    } t_cell;

    // Maps a HID usage code to its matrix cell.
    function automatic t_cell usage_lookup(input t_code code);
        logic [6:0] rc;
        logic       hit;
        t_cell      loc;
        hit = 1'b1;
        rc  = 7'd0;
        unique case (code)
            8'h27: rc = {4'd0, 3'd0};
            8'h1E: rc = {4'd0, 3'd1};
            8'h1F: rc = {4'd0, 3'd2};
            8'h20: rc = {4'd0, 3'd3};
            8'h21: rc = {4'd0, 3'd4};
            8'h22: rc = {4'd0, 3'd5};
            8'h23: rc = {4'd0, 3'd6};
            8'h24: rc = {4'd0, 3'd7};
            8'h25: rc = {4'd1, 3'd0};
            8'h26: rc = {4'd1, 3'd1};
            8'h2D: rc = {4'd1, 3'd2};
            8'h2E: rc = {4'd1, 3'd3};
            8'h31: rc = {4'd1, 3'd4};
            8'h2F: rc = {4'd1, 3'd5};
            8'h30: rc = {4'd1, 3'd6};
            8'h33: rc = {4'd1, 3'd7};
            8'h34: rc = {4'd2, 3'd0};
            8'h04: rc = {4'd2, 3'd1};
            8'h05: rc = {4'd2, 3'd2};
            8'h06: rc = {4'd2, 3'd3};
            8'h07: rc = {4'd2, 3'd4};
            8'h08: rc = {4'd2, 3'd5};
            8'h09: rc = {4'd2, 3'd6};
            8'h0A: rc = {4'd2, 3'd7};
            8'h0B: rc = {4'd3, 3'd0};
            8'h0C: rc = {4'd3, 3'd1};
            8'h0D: rc = {4'd3, 3'd2};
            8'h0E: rc = {4'd3, 3'd3};
            8'h0F: rc = {4'd3, 3'd4};
            8'h10: rc = {4'd3, 3'd5};
            8'h11: rc = {4'd3, 3'd6};
            8'h12: rc = {4'd3, 3'd7};
            8'h13: rc = {4'd4, 3'd0};
            8'h14: rc = {4'd4, 3'd1};
            8'h15: rc = {4'd4, 3'd2};
            8'h16: rc = {4'd4, 3'd3};
            8'h17: rc = {4'd4, 3'd4};
            8'h18: rc = {4'd4, 3'd5};
            8'h19: rc = {4'd4, 3'd6};
            8'h1A: rc = {4'd4, 3'd7};
            8'h1B: rc = {4'd5, 3'd0};
            8'h1C: rc = {4'd5, 3'd1};
            8'h1D: rc = {4'd5, 3'd2};
            8'hE1: rc = {4'd5, 3'd3};
            8'hE0: rc = {4'd5, 3'd4};
            8'h35: rc = {4'd5, 3'd5};
            8'h36: rc = {4'd5, 3'd6};
            8'h37: rc = {4'd5, 3'd7};
            8'h38: rc = {4'd6, 3'd0};
            8'hE5: rc = {4'd6, 3'd1};
            8'h52: rc = {4'd6, 3'd2};
            8'h4F: rc = {4'd6, 3'd3};
            8'h51: rc = {4'd6, 3'd4};
            8'h50: rc = {4'd6, 3'd5};
            8'h4C: rc = {4'd6, 3'd6};
            8'h49: rc = {4'd6, 3'd7};
            8'h4A: rc = {4'd7, 3'd0};
            8'h4B: rc = {4'd7, 3'd1};
            8'h4E: rc = {4'd7, 3'd2};
            8'h3A: rc = {4'd7, 3'd3};
            8'h3B: rc = {4'd7, 3'd4};
            8'h3C: rc = {4'd7, 3'd5};
            8'h3D: rc = {4'd7, 3'd6};
            8'h3E: rc = {4'd7, 3'd7};
            8'h29: rc = {4'd8, 3'd0};
            8'h2B: rc = {4'd8, 3'd1};
            8'h4D: rc = {4'd8, 3'd2};
            8'h2A: rc = {4'd8, 3'd3};
            8'h28: rc = {4'd8, 3'd4};
            8'h2C: rc = {4'd8, 3'd5};
            8'hE2: rc = {4'd8, 3'd6};
            8'h39: rc = {4'd8, 3'd7};
            8'h59: rc = {4'd9, 3'd0};
            8'h5A: rc = {4'd9, 3'd1};
            8'h5B: rc = {4'd9, 3'd2};
            8'h5C: rc = {4'd9, 3'd3};
            8'h5D: rc = {4'd9, 3'd4};
            8'h5E: rc = {4'd9, 3'd5};
            8'h5F: rc = {4'd9, 3'd6};
            8'h60: rc = {4'd9, 3'd7};
            8'h61: rc = {4'd10, 3'd0};
            8'h62: rc = {4'd10, 3'd1};
            8'h56: rc = {4'd10, 3'd2};
            8'h57: rc = {4'd10, 3'd3};
            8'h55: rc = {4'd10, 3'd4};
            8'h54: rc = {4'd10, 3'd5};
            8'h63: rc = {4'd10, 3'd6};
            8'h58: rc = {4'd10, 3'd7};
            default: hit = 1'b0;
        endcase
        loc.hit = hit;
        loc.row = rc[6:3];
        loc.col = rc[2:0];
        return loc;
    endfunction

    // A cell that falls outside the matrix is ignored.
    function automatic logic cell_usable(input t_cell loc);
        return loc.hit && ({1'b0, loc.row} < 5'(MATRIX_ROWS))
            && ({1'b0, loc.col} < 4'(MATRIX_COLS));
    endfunction

endpackage

// ===== rtl/core/hrk_if.sv =====
`timescale 1ns / 1ps

interface hrk_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] modifier_bits;
    logic [7:0] keycode_0;
    logic [7:0] keycode_1;
    logic [7:0] keycode_2;
    logic [7:0] keycode_3;
    logic [7:0] keycode_4;
    logic [7:0] keycode_5;
    logic [3:0] row_pins;
    logic       dir_read;

    modport source (
        output valid, req_type, modifier_bits, keycode_0, keycode_1, keycode_2,
               keycode_3, keycode_4, keycode_5, row_pins, dir_read,
        input  ready
    );

    modport sink (
        input  valid, req_type, modifier_bits, keycode_0, keycode_1, keycode_2,
               keycode_3, keycode_4, keycode_5, row_pins, dir_read,
        output ready
    );
endinterface

interface hrk_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] column_levels;
    logic       drive_enable;

    modport source (
        output valid, column_levels, drive_enable,
        input  ready
    );

    modport sink (
        input  valid, column_levels, drive_enable,
        output ready
    );
endinterface

// ===== rtl/core/hrk_ctrl.sv =====
`timescale 1ns / 1ps

module hrk_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_req_type,
    input  hrk_pkg::t_status i_status,
    output logic             o_in_ready,
    output hrk_pkg::t_cmd    o_cmd
);
    import hrk_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_slot     = r_slot;
        o_in_ready = 1'b0;
        o_cmd      = '{op: OP_NONE, slot: r_slot};
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = i_status.out_free;
                if (i_in_valid && i_status.out_free) begin
                    if (i_in_req_type == REQ_SCAN) begin
                        o_cmd.op = OP_SCAN;
                    end else begin
                        o_cmd.op = OP_LOAD;
                        n_state  = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                o_cmd.op = OP_MOD;
                n_slot   = '0;
                n_state  = i_status.keys_empty ? ST_CLEAR : ST_PRESS;
            end
            ST_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                n_state  = ST_IDLE;
            end
            ST_PRESS: begin
                o_cmd.op = OP_PRESS;
                if (r_slot == LAST_SLOT) begin
                    n_slot  = '0;
                    n_state = ST_RELEASE;
                end else begin
                    n_slot = r_slot + SLOT_W'(1);
                end
            end
            ST_RELEASE: begin
                o_cmd.op = OP_RELEASE;
                if (r_slot == LAST_SLOT) begin
                    n_slot  = '0;
                    n_state = ST_COMMIT;
                end else begin
                    n_slot = r_slot + SLOT_W'(1);
                end
            end
            ST_COMMIT: begin
                o_cmd.op = OP_COMMIT;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_report_starts_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_req_type == REQ_REPORT) |=> r_state == ST_MOD)
        else $error("accepted report did not start the update sequence");

    a_press_to_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PRESS) && (r_slot == LAST_SLOT)
            |=> (r_state == ST_RELEASE) && (r_slot == '0))
        else $error("release pass did not follow the last press slot");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_slot} < (SLOT_W + 1)'(REPORT_SLOTS))
        else $error("slot counter left the report range");

endmodule

// ===== rtl/core/hrk_dp.sv =====
`timescale 1ns / 1ps

module hrk_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hrk_pkg::t_cmd    i_cmd,
    input  hrk_pkg::t_req    i_req,
    input  logic             i_out_ready,
    output hrk_pkg::t_status o_status,
    output logic             o_out_valid,
    output logic [7:0]       o_column_levels,
    output logic             o_drive_enable
);
    import hrk_pkg::*;

    t_row       r_matrix    [MATRIX_ROWS];
    t_row       n_matrix    [MATRIX_ROWS];
    t_code      r_prev_keys [REPORT_SLOTS];
    t_code      n_prev_keys [REPORT_SLOTS];
    t_code      r_keys      [REPORT_SLOTS];
    logic [7:0] r_mod;
    logic [7:0] r_mod_prev;
    logic [7:0] n_mod_prev;
    logic       r_out_valid;
    logic [7:0] r_levels;
    logic       r_drive;

    t_code      w_key_code;
    t_code      w_prev_code;
    logic       w_key_in_prev;
    logic       w_prev_in_keys;
    t_cell      w_cell;
    logic [3:0] w_scan_row;
    logic [7:0] w_scan_levels;
    logic       w_keys_empty;

    always_comb begin
        w_keys_empty = 1'b1;
        for (int i = 0; i < REPORT_SLOTS; i++) begin
            if (r_keys[i] != '0) begin
                w_keys_empty = 1'b0;
            end
        end
    end

    assign o_status = '{keys_empty: w_keys_empty, out_free: (!r_out_valid || i_out_ready)};

    assign w_key_code  = r_keys[i_cmd.slot];
    assign w_prev_code = r_prev_keys[i_cmd.slot];

    always_comb begin
        w_key_in_prev  = 1'b0;
        w_prev_in_keys = 1'b0;
        for (int j = 0; j < REPORT_SLOTS; j++) begin
            if (r_prev_keys[j] == w_key_code) begin
                w_key_in_prev = 1'b1;
            end
            if (r_keys[j] == w_prev_code) begin
                w_prev_in_keys = 1'b1;
            end
        end
    end

    assign w_cell = usage_lookup((i_cmd.op == OP_PRESS) ? w_key_code : w_prev_code);

    always_comb begin
        t_cell v_mod_cell;
        n_matrix    = r_matrix;
        n_prev_keys = r_prev_keys;
        n_mod_prev  = r_mod_prev;
        v_mod_cell  = '0;
        unique case (i_cmd.op)
            OP_MOD: begin
                if (r_mod != r_mod_prev) begin
                    for (int b = 0; b < 8; b++) begin
                        v_mod_cell = usage_lookup(MOD_CODE_BASE + 8'(b));
                        if (cell_usable(v_mod_cell)) begin
                            n_matrix[v_mod_cell.row[ROW_W-1:0]][v_mod_cell.col[COL_W-1:0]]
                                = r_mod[b];
                        end
                    end
                    n_mod_prev = r_mod;
                end
            end
            OP_CLEAR: begin
                for (int r = 0; r < MATRIX_ROWS; r++) begin
                    n_matrix[r] = '0;
                end
                for (int s = 0; s < REPORT_SLOTS; s++) begin
                    n_prev_keys[s] = '0;
                end
            end
            OP_PRESS: begin
                if ((w_key_code != '0) && !w_key_in_prev && cell_usable(w_cell)) begin
                    n_matrix[w_cell.row[ROW_W-1:0]][w_cell.col[COL_W-1:0]] = 1'b1;
                end
            end
            OP_RELEASE: begin
                if ((w_prev_code != '0) && !w_prev_in_keys && cell_usable(w_cell)) begin
                    n_matrix[w_cell.row[ROW_W-1:0]][w_cell.col[COL_W-1:0]] = 1'b0;
                end
            end
            OP_COMMIT: begin
                n_prev_keys = r_keys;
            end
            default: begin
            end
        endcase
    end

    // Columns beyond the matrix width read as released.
    always_comb begin
        w_scan_row    = ~i_req.row_pins;
        w_scan_levels = '1;
        if (i_req.dir_read && ({1'b0, w_scan_row} < 5'(MATRIX_ROWS))) begin
            w_scan_levels[MATRIX_COLS-1:0] = ~r_matrix[w_scan_row[ROW_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < MATRIX_ROWS; r++) begin
                r_matrix[r] <= '0;
            end
            for (int s = 0; s < REPORT_SLOTS; s++) begin
                r_prev_keys[s] <= '0;
            end
            r_mod_prev  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_matrix    <= n_matrix;
            r_prev_keys <= n_prev_keys;
            r_mod_prev  <= n_mod_prev;
            if (i_cmd.op == OP_SCAN) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_mod <= i_req.modifier_bits;
            for (int s = 0; s < REPORT_SLOTS; s++) begin
                r_keys[s] <= i_req.keycodes[s];
            end
        end
        if (i_cmd.op == OP_SCAN) begin
            r_levels <= w_scan_levels;
            r_drive  <= i_req.dir_read;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_column_levels = r_levels;
    assign o_drive_enable  = r_drive;

    a_valid_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.op == OP_SCAN))
        else $error("result appeared without a scan transaction");

    a_scan_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_SCAN) |-> o_status.out_free)
        else $error("scan overwrote a result that was not taken");

    a_released_drive_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_drive |-> (r_levels == 8'hFF))
        else $error("columns driven low while the direction line was low");

endmodule

// ===== rtl/core/hid_report_to_key_matrix_unit.sv =====
`timescale 1ns / 1ps
// Scan: the result is registered and valid in the cycle after acceptance; scans
// can be accepted every cycle while the result register is free or being read
// and no report update runs. Report: an update after acceptance (modifiers, six
// press steps, six release steps, commit), or modifiers and clear for an empty
// report; then back in idle. Synchronous active-low reset clears the key matrix,
// the previous key list, the previous modifiers and the result valid flag.

module hid_report_to_key_matrix_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hrk_req_if.sink   i_req,
    hrk_rsp_if.source o_rsp
);
    import hrk_pkg::*;

    t_req    w_req;
    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    always_comb begin
        w_req.req_type      = i_req.req_type;
        w_req.modifier_bits = i_req.modifier_bits;
        w_req.keycodes[0]   = i_req.keycode_0;
        w_req.keycodes[1]   = i_req.keycode_1;
        w_req.keycodes[2]   = i_req.keycode_2;
        w_req.keycodes[3]   = i_req.keycode_3;
        w_req.keycodes[4]   = i_req.keycode_4;
        w_req.keycodes[5]   = i_req.keycode_5;
        w_req.row_pins      = i_req.row_pins;
        w_req.dir_read      = i_req.dir_read;
    end

    assign i_req.ready = w_in_ready;

    hrk_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_req.valid),
        .i_in_req_type (i_req.req_type),
        .i_status      (w_status),
        .o_in_ready    (w_in_ready),
        .o_cmd         (w_cmd)
    );

    hrk_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_req           (w_req),
        .i_out_ready     (o_rsp.ready),
        .o_status        (w_status),
        .o_out_valid     (o_rsp.valid),
        .o_column_levels (o_rsp.column_levels),
        .o_drive_enable  (o_rsp.drive_enable)
    );

endmodule

// ===== tb/tb_hid_report_to_key_matrix_unit.sv =====
`timescale 1ns / 1ps

module tb_hid_report_to_key_matrix_unit;
    import hrk_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int RANDOM_ITEMS = 1075;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_SHOWN    = 10;
    localparam int CELL_COUNT   = 88;

    // Usage code of each matrix cell, row by row, column 0 first.
    localparam logic [0:CELL_COUNT-1][7:0] CELL_CODES = {
        8'h27, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
        8'h25, 8'h26, 8'h2D, 8'h2E, 8'h31, 8'h2F, 8'h30, 8'h33,
        8'h34, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A,
        8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 8'h10, 8'h11, 8'h12,
        8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1A,
        8'h1B, 8'h1C, 8'h1D, 8'hE1, 8'hE0, 8'h35, 8'h36, 8'h37,
        8'h38, 8'hE5, 8'h52, 8'h4F, 8'h51, 8'h50, 8'h4C, 8'h49,
        8'h4A, 8'h4B, 8'h4E, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E,
        8'h29, 8'h2B, 8'h4D, 8'h2A, 8'h28, 8'h2C, 8'hE2, 8'h39,
        8'h59, 8'h5A, 8'h5B, 8'h5C, 8'h5D, 8'h5E, 8'h5F, 8'h60,
        8'h61, 8'h62, 8'h56, 8'h57, 8'h55, 8'h54, 8'h63, 8'h58
    };

    typedef struct packed {
        logic            kind;
        logic [7:0]      mods;
        logic [5:0][7:0] keys;
        logic [3:0]      row_pins;
        logic            dir_read;
    } t_key_req;

    typedef struct packed {
        logic [7:0] levels;
        logic       drive;
    } t_scan_reply;

    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_SPARSE,
        STALL_RHYTHM
    } t_stall_mode;

    logic i_clk;
    logic i_rst_n;

    hrk_req_if req_bus();
    hrk_rsp_if rsp_bus();

    hid_report_to_key_matrix_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    logic [7:0]      pressed_rows [16];
    logic [5:0][7:0] last_keys;
    logic [7:0]      last_mods;
    logic [5:0][7:0] typing_keys;
    logic [7:0]      typing_mods;
    t_scan_reply     expected_replies [$];
    t_scan_reply     oldest_reply;
    int              mismatch_count = 0;
    int unsigned     cycle_count = 0;
    int              burst_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void set_key_cell(input logic [7:0] code, input logic down);
        int r;
        int c;
        for (int i = 0; i < CELL_COUNT; i++) begin
            if (CELL_CODES[i] == code) begin
                r = i / 8;
                c = i % 8;
                if (r < MATRIX_ROWS && c < MATRIX_COLS) begin
                    pressed_rows[r][c] = down;
                end
                return;
            end
        end
    endfunction

    function automatic bit key_listed(input logic [5:0][7:0] list, input logic [7:0] code);
        for (int j = 0; j < REPORT_SLOTS; j++) begin
            if (list[j] == code) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void update_matrix(input t_key_req it);
        logic empty;
        empty = 1'b1;
        if (it.mods != last_mods) begin
            for (int b = 0; b < 8; b++) begin
                set_key_cell(MOD_CODE_BASE + 8'(b), it.mods[b]);
            end
            last_mods = it.mods;
        end
        for (int j = 0; j < REPORT_SLOTS; j++) begin
            if (it.keys[j] != 8'h00) begin
                empty = 1'b0;
            end
        end
        if (empty) begin
            for (int r = 0; r < 16; r++) begin
                pressed_rows[r] = '0;
            end
            last_keys = '0;
            return;
        end
        for (int j = 0; j < REPORT_SLOTS; j++) begin
            if (it.keys[j] != 8'h00 && !key_listed(last_keys, it.keys[j])) begin
                set_key_cell(it.keys[j], 1'b1);
            end
        end
        for (int j = 0; j < REPORT_SLOTS; j++) begin
            if (last_keys[j] != 8'h00 && !key_listed(it.keys, last_keys[j])) begin
                set_key_cell(last_keys[j], 1'b0);
            end
        end
        last_keys = it.keys;
    endfunction

    function automatic t_scan_reply scan_reply(input t_key_req it);
        t_scan_reply rep;
        logic [3:0]  row;
        row        = ~it.row_pins;
        rep.drive  = it.dir_read;
        rep.levels = 8'hFF;
        if (it.dir_read && row < MATRIX_ROWS) begin
            rep.levels = ~pressed_rows[row];
        end
        return rep;
    endfunction

    function automatic t_key_req report_item(input logic [7:0] mods,
                                             input logic [5:0][7:0] keys);
        t_key_req it;
        it.kind     = REQ_REPORT;
        it.mods     = mods;
        it.keys     = keys;
        it.row_pins = 4'($urandom);
        it.dir_read = 1'($urandom);
        return it;
    endfunction

    function automatic t_key_req scan_item(input int row, input logic dir);
        t_key_req it;
        it.kind = REQ_SCAN;
        it.mods = 8'($urandom);
        for (int j = 0; j < 6; j++) begin
            it.keys[j] = 8'($urandom);
        end
        it.row_pins = ~4'(row);
        it.dir_read = dir;
        return it;
    endfunction

    task automatic send_item(input t_key_req it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                @(negedge i_clk);
                req_bus.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge i_clk);
        req_bus.req_type      <= it.kind;
        req_bus.modifier_bits <= it.mods;
        req_bus.keycode_0     <= it.keys[0];
        req_bus.keycode_1     <= it.keys[1];
        req_bus.keycode_2     <= it.keys[2];
        req_bus.keycode_3     <= it.keys[3];
        req_bus.keycode_4     <= it.keys[4];
        req_bus.keycode_5     <= it.keys[5];
        req_bus.row_pins      <= it.row_pins;
        req_bus.dir_read      <= it.dir_read;
        req_bus.valid         <= 1'b1;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        if (it.kind == REQ_SCAN) begin
            expected_replies.push_back(scan_reply(it));
        end else begin
            update_matrix(it);
        end
    endtask

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    task automatic test_reset_state;
        send_item(scan_item(0, 1'b1));
        send_item(scan_item(MATRIX_ROWS - 1, 1'b1));
    endtask

    task automatic test_modifier_cells;
        // Only left ctrl, left shift, left alt and right shift have cells.
        send_item(report_item(8'hFF, {40'd0, 8'h04}));
        send_item(scan_item(5, 1'b1));
        send_item(scan_item(6, 1'b1));
        send_item(scan_item(8, 1'b1));
        send_item(report_item(8'hFF, {40'd0, 8'h05}));
        send_item(scan_item(5, 1'b1));
        send_item(scan_item(2, 1'b1));
        send_item(report_item(8'h00, {40'd0, 8'h05}));
        send_item(scan_item(5, 1'b1));
    endtask

    task automatic test_empty_report;
        send_item(report_item(8'h02, {8'h0A, 32'd0, 8'h27}));
        send_item(report_item(8'h02, '0));
        send_item(scan_item(0, 1'b1));
        // The modifier byte is unchanged, so shift is not set again.
        send_item(report_item(8'h02, {40'd0, 8'h04}));
        send_item(scan_item(5, 1'b1));
        send_item(scan_item(2, 1'b1));
    endtask

    task automatic test_press_release;
        // Duplicate slots, codes without a cell, and a modifier usage sent as a key.
        send_item(report_item(8'h00, {8'hFF, 8'h01, 8'hE3, 8'hE1, 8'h04, 8'h04}));
        send_item(report_item(8'h00, {40'd0, 8'h58}));
        send_item(scan_item(5, 1'b1));
        send_item(scan_item(10, 1'b1));
    endtask

    task automatic test_row_select;
        send_item(scan_item(10, 1'b0));
        send_item(scan_item(11, 1'b1));
        send_item(scan_item(15, 1'b1));
    endtask

    task automatic test_random_traffic;
        logic [5:0][7:0] keys;
        int              pick;
        int              row;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 1) == 1) begin
                row = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                  : $urandom_range(0, MATRIX_ROWS - 1);
                send_item(scan_item(row, $urandom_range(0, 9) != 0));
            end else begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    keys = '0;
                end else if (pick < 3) begin
                    for (int j = 0; j < 6; j++) begin
                        keys[j] = 8'($urandom);
                    end
                end else begin
                    keys = typing_keys;
                    for (int j = 0; j < 6; j++) begin
                        case ($urandom_range(0, 9))
                            0: keys[j] = 8'h00;
                            1, 2: keys[j] = CELL_CODES[$urandom_range(0, CELL_COUNT - 1)];
                            3: keys[j] = MOD_CODE_BASE + 8'($urandom_range(0, 7));
                            default: keys[j] = typing_keys[j];
                        endcase
                    end
                end
                typing_keys = keys;
                if ($urandom_range(0, 2) == 0) begin
                    typing_mods = 8'($urandom);
                end
                send_item(report_item(typing_mods, keys));
            end
        end
    endtask

    initial begin : ready_pattern
        t_stall_mode mode;
        int          span;
        rsp_bus.ready = 1'b0;
        forever begin
            mode = t_stall_mode'($urandom_range(0, 3));
            span = $urandom_range(16, 96);
            for (int k = 0; k < span; k++) begin
                @(negedge i_clk);
                case (mode)
                    STALL_NONE:   rsp_bus.ready <= 1'b1;
                    STALL_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
                    STALL_SPARSE: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
                    default:      rsp_bus.ready <= ((k % 6) < 4);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (expected_replies.size() == 0) begin
                note_mismatch($sformatf("unexpected transaction: column_levels %02h drive %b",
                                        rsp_bus.column_levels, rsp_bus.drive_enable));
            end else begin
                oldest_reply = expected_replies.pop_front();
                if (rsp_bus.column_levels !== oldest_reply.levels) begin
                    note_mismatch($sformatf("column_levels expected %02h got %02h",
                                            oldest_reply.levels, rsp_bus.column_levels));
                end
                if (rsp_bus.drive_enable !== oldest_reply.drive) begin
                    note_mismatch($sformatf("drive_enable expected %b got %b",
                                            oldest_reply.drive, rsp_bus.drive_enable));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_hid_report_to_key_matrix_unit: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n               = 1'b0;
        req_bus.valid         = 1'b0;
        req_bus.req_type      = REQ_REPORT;
        req_bus.modifier_bits = '0;
        req_bus.keycode_0     = '0;
        req_bus.keycode_1     = '0;
        req_bus.keycode_2     = '0;
        req_bus.keycode_3     = '0;
        req_bus.keycode_4     = '0;
        req_bus.keycode_5     = '0;
        req_bus.row_pins      = '1;
        req_bus.dir_read      = 1'b0;
        for (int r = 0; r < 16; r++) begin
            pressed_rows[r] = '0;
        end
        last_keys   = '0;
        last_mods   = '0;
        typing_keys = '0;
        typing_mods = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_modifier_cells();
        test_empty_report();
        test_press_release();
        test_row_select();
        test_random_traffic();

        @(negedge i_clk);
        req_bus.valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_hid_report_to_key_matrix_unit: PASS");
        end else begin
            $display("tb_hid_report_to_key_matrix_unit: FAIL");
        end
        $finish;
    end

endmodule
